### design/slpcf_pkg.sv
// Shared constants, types and elaboration-time CRC tables for the framer.
// Used by slpcf_crc_step and the top level; depends on nothing else.
`default_nettype none

package slpcf_pkg;

   localparam int CrcWidth = 32;
   localparam int ByteWidth = 8;
   localparam int ByteCount = 256;

   localparam logic [CrcWidth-1:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [CrcWidth-1:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [ByteWidth-1:0] SYNC_BYTE = 8'h16;
   localparam logic [ByteWidth-1:0] ASCII_ZERO = 8'h30;

   typedef logic [CrcWidth-1:0] crc_type;
   typedef logic [ByteWidth-1:0] byte_type;
   typedef crc_type crc_table_type [ByteCount];
   typedef crc_type crc_matrix_type [CrcWidth];

   // Elaboration only: one ASCII octet through the reflected CRC, bit by bit.
   function automatic crc_type crc_feed_octet(crc_type crc, byte_type octet);
      crc_type c;
      c = crc ^ {24'h0, octet};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // Elaboration only: a frame byte, MSB first, as eight ASCII digits.
   function automatic crc_type crc_feed_frame_byte(crc_type crc, byte_type fb);
      crc_type c;
      c = crc;
      for (int b = ByteWidth - 1; b >= 0; b--) begin
         c = crc_feed_octet(c, ASCII_ZERO | {7'h0, fb[b]});
      end
      return c;
   endfunction

   // Contribution of each byte value with a zero starting CRC.
   function automatic crc_table_type crc_byte_table_build();
      crc_table_type t;
      for (int b = 0; b < ByteCount; b++) begin
         t[b] = crc_feed_frame_byte('0, byte_type'(b));
      end
      return t;
   endfunction

   // Contribution of each starting CRC bit; the update is affine, so the
   // constant part is removed here and carried by the byte table.
   function automatic crc_matrix_type crc_matrix_build();
      crc_matrix_type m;
      crc_type base;
      base = crc_feed_frame_byte('0, '0);
      for (int j = 0; j < CrcWidth; j++) begin
         m[j] = crc_feed_frame_byte(crc_type'(1) << j, '0) ^ base;
      end
      return m;
   endfunction

   localparam crc_table_type CRC_BYTE_TABLE = crc_byte_table_build();
   localparam crc_matrix_type CRC_STATE_MATRIX = crc_matrix_build();

endpackage

`default_nettype wire

### design/sync_length_parity_crc_framer.sv
// Top level of the character framer: input register, byte sequencer, result register.
// Depends on slpcf_pkg and slpcf_crc_step.
`default_nettype none

// A character that does not start a frame gives one beat, so such characters
// stream at one per cycle while the output is not stalled. A character marked
// first gives four beats (two 0x16 sync bytes, the length byte, then the data
// byte), and the next character is taken on the cycle its data byte moves to
// the output register. The CRC advances one frame byte per cycle, unless the
// output stalls, through a single XOR-matrix step; the final inverted CRC comes
// with the data byte of a character marked last, flagged by rsp_crc_valid. An
// accepted character is held in the input register; each beat is registered.
module sync_length_parity_crc_framer (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire [6:0]  req_data_char,
   input  wire [7:0]  req_msg_length,
   input  wire        req_first_char,
   input  wire        req_last_char,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic [7:0] rsp_frame_byte,
   output logic [31:0] rsp_frame_crc,
   output logic       rsp_crc_valid,
   output logic       rsp_last_of_run
);

   localparam logic [1:0] PH_SYNC0  = 2'd0;
   localparam logic [1:0] PH_SYNC1  = 2'd1;
   localparam logic [1:0] PH_LENGTH = 2'd2;
   localparam logic [1:0] PH_DATA   = 2'd3;

   logic       in_valid_ff;
   logic [6:0] in_char_ff;
   logic [7:0] in_len_ff;
   logic       in_last_ff;
   logic [1:0] phase_ff;

   slpcf_pkg::crc_type crc_ff;
   slpcf_pkg::crc_type crc_src;
   slpcf_pkg::crc_type crc_in;

   logic                 rsp_valid_ff;
   slpcf_pkg::byte_type  rsp_byte_ff;
   slpcf_pkg::crc_type   rsp_crc_ff;
   logic                 rsp_crc_valid_ff;
   logic                 rsp_last_ff;

   slpcf_pkg::byte_type rsp_byte_in;
   slpcf_pkg::crc_type  rsp_crc_in;
   logic                rsp_crc_valid_in;

   logic emit;
   logic final_beat;
   logic req_accept;

   assign emit       = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign final_beat = emit && (phase_ff == PH_DATA);
   assign req_stall  = in_valid_ff && !final_beat;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      unique case (phase_ff)
         PH_SYNC0, PH_SYNC1: rsp_byte_in = slpcf_pkg::SYNC_BYTE;
         PH_LENGTH:          rsp_byte_in = in_len_ff;
         PH_DATA:            rsp_byte_in = {in_char_ff, ~(^in_char_ff)};
         default:            rsp_byte_in = {in_char_ff, ~(^in_char_ff)};
      endcase
   end

   // Restart the CRC on the first sync byte of a frame.
   assign crc_src = (phase_ff == PH_SYNC0) ? slpcf_pkg::CRC_INIT : crc_ff;

   slpcf_crc_step u_crc_step (
      .crc_cur    (crc_src),
      .frame_byte (rsp_byte_in),
      .crc_next   (crc_in)
   );

   assign rsp_crc_valid_in = (phase_ff == PH_DATA) && in_last_ff;
   assign rsp_crc_in       = rsp_crc_valid_in ? ~crc_in : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PH_SYNC0;
      end else if (req_accept) begin
         in_valid_ff <= 1'b1;
         phase_ff    <= req_first_char ? PH_SYNC0 : PH_DATA;
      end else if (final_beat) begin
         in_valid_ff <= 1'b0;
      end else if (emit) begin
         phase_ff <= phase_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_char_ff <= req_data_char;
         in_len_ff  <= req_msg_length;
         in_last_ff <= req_last_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= slpcf_pkg::CRC_INIT;
      end else if (emit) begin
         crc_ff <= rsp_crc_valid_in ? slpcf_pkg::CRC_INIT : crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Hold the result beat while stalled.
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_byte_ff      <= rsp_byte_in;
         rsp_crc_ff       <= rsp_crc_in;
         rsp_crc_valid_ff <= rsp_crc_valid_in;
         rsp_last_ff      <= (phase_ff == PH_DATA);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frame_byte  = rsp_byte_ff;
   assign rsp_frame_crc   = rsp_crc_ff;
   assign rsp_crc_valid   = rsp_crc_valid_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

`default_nettype wire

### design/slpcf_crc_step.sv
// One frame byte of CRC update: XOR matrix on the running CRC plus a byte table.
// Depends on slpcf_pkg for the precomputed matrix and table.
`default_nettype none

module slpcf_crc_step (
   input  wire slpcf_pkg::crc_type  crc_cur,
   input  wire slpcf_pkg::byte_type frame_byte,
   output slpcf_pkg::crc_type       crc_next
);

   slpcf_pkg::crc_type state_part;

   always_comb begin
      state_part = '0;
      for (int j = 0; j < slpcf_pkg::CrcWidth; j++) begin
         if (crc_cur[j]) begin
            state_part = state_part ^ slpcf_pkg::CRC_STATE_MATRIX[j];
         end
      end
   end

   assign crc_next = state_part ^ slpcf_pkg::CRC_BYTE_TABLE[frame_byte];

endmodule

`default_nettype wire

### design/slpcf_checker.sv
// Port-level checks for the framer, attached to the top level by bind.
// Depends only on the top level's port list.
`default_nettype none

module slpcf_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_stall,
   input wire [6:0]  req_data_char,
   input wire [7:0]  req_msg_length,
   input wire        req_first_char,
   input wire        req_last_char,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire [7:0]  rsp_frame_byte,
   input wire [31:0] rsp_frame_crc,
   input wire        rsp_crc_valid,
   input wire        rsp_last_of_run
);

   // A stalled input beat stays put.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data_char)
         && $stable(req_msg_length) && $stable(req_first_char)
         && $stable(req_last_char))
      else $error("stalled input beat changed");

   // A stalled result beat keeps its byte, CRC and CRC flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame_byte)
         && $stable(rsp_frame_crc) && $stable(rsp_crc_valid))
      else $error("stalled result beat changed");

   // The final CRC only rides on the closing beat of a character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_crc_valid |-> rsp_last_of_run)
      else $error("final CRC on a non-closing beat");

   // CRC field reads zero whenever it is not flagged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_crc_valid |-> rsp_frame_crc == 32'h0)
      else $error("unflagged CRC field not zero");

   // No result beat right out of reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

endmodule

bind sync_length_parity_crc_framer slpcf_checker u_slpcf_checker (.*);

`default_nettype wire
